/* hw/rtl/obst_pkg.sv */
package obst_pkg;

	// Table geometry.
	localparam int TICKERS     = 4;
	localparam int ORDER_SLOTS = 8;
	localparam int TOTAL_SLOTS = TICKERS * ORDER_SLOTS;
	localparam int ADDR_W      = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
	localparam int TK_W        = (TICKERS > 1) ? $clog2(TICKERS) : 1;
	localparam int SL_W        = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;

	// Reset value of the snapshot period register.
	localparam logic [31:0] PERIOD_RESET = 32'd60000;

	// Input item selector.
	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// Update types that touch the table.
	localparam logic [2:0] UPD_ADD    = 3'd0;
	localparam logic [2:0] UPD_MODIFY = 3'd1;
	localparam logic [2:0] UPD_CANCEL = 3'd2;

	// Result record kinds.
	localparam logic [2:0] KIND_START = 3'd0;
	localparam logic [2:0] KIND_CLEAR = 3'd1;
	localparam logic [2:0] KIND_ORDER = 3'd2;
	localparam logic [2:0] KIND_END   = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	// Error codes.
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OCCUPIED = 2'd1;
	localparam logic [1:0] ERR_EMPTY    = 2'd2;
	localparam logic [1:0] ERR_SIDE     = 2'd3;

	// One input item.
	typedef struct packed {
		logic               func;
		logic [2:0]         update_type;
		logic [1:0]         ticker;
		logic [2:0]         order_slot;
		logic [1:0]         side;
		logic signed [31:0] price;
		logic [31:0]        quantity;
		logic [31:0]        priority_req;
		logic [31:0]        seq_num;
	} item_t;

	// One result record.
	typedef struct packed {
		logic [5:0]         msg_index;
		logic [2:0]         msg_kind;
		logic [1:0]         out_ticker;
		logic [2:0]         out_slot;
		logic [1:0]         out_side;
		logic signed [31:0] out_price;
		logic [31:0]        out_quantity;
		logic [31:0]        out_priority;
		logic [31:0]        out_seq;
		logic [1:0]         error_code;
		logic               seq_gap;
		logic               last;
	} rec_t;

	// Contents of one order slot in the table memory.
	typedef struct packed {
		logic [1:0]  side;
		logic [31:0] price;
		logic [31:0] quantity;
		logic [31:0] priority_val;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       accept;
		logic       commit;
		logic       emit;
		logic [2:0] emit_kind;
		logic       scan_read;
		logic       walk_next;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_tick;
		logic snap_due;
		logic broken;
		logic out_free;
		logic scan_valid;
		logic slot_last;
		logic ticker_last;
	} stat_t;

endpackage

/* hw/rtl/obst_ram.sv */
module obst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/obst_ctrl.sv */
module obst_ctrl import obst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_ERROR = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;
	localparam logic [2:0] ST_ORDER = 3'd6;
	localparam logic [2:0] ST_END   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] walk_state;

	assign in_ready = (state_q == ST_IDLE);

	// Where the snapshot walk goes after finishing the current slot.
	always_comb begin
		if (!stat.slot_last) begin
			walk_state = ST_SCAN;
		end else if (stat.ticker_last) begin
			walk_state = ST_END;
		end else begin
			walk_state = ST_CLEAR;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.emit_kind = KIND_ERROR;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					if (stat.in_tick) begin
						state_d = stat.snap_due ? ST_START : ST_IDLE;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (stat.broken) begin
					state_d = ST_ERROR;
				end else begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_ERROR: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_ERROR;
					state_d       = ST_IDLE;
				end
			end
			ST_START: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_START;
					state_d       = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_CLEAR;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_valid) begin
					cmd.scan_read = 1'b1;
					state_d       = ST_ORDER;
				end else begin
					cmd.walk_next = 1'b1;
					state_d       = walk_state;
				end
			end
			ST_ORDER: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_ORDER;
					cmd.walk_next = 1'b1;
					state_d       = walk_state;
				end
			end
			ST_END: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_END;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/obst_dp.sv */
module obst_dp import obst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       in_item,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic        out_ready,
	output logic        out_valid,
	output rec_t        out_rec
);

	// Configuration and running counters.
	logic [31:0] period_q;
	logic [31:0] elapsed_q;
	logic [31:0] elapsed_inc;
	logic [31:0] last_seq_q;

	// Live-order flags, one per slot.
	logic [TOTAL_SLOTS-1:0] valid_q;

	// Registered update item.
	item_t             item_q;
	logic [ADDR_W-1:0] addr_q;
	logic              in_range_q;

	// Input address decode.
	logic              in_range;
	logic [ADDR_W-1:0] in_addr;

	// Snapshot walk.
	logic [TK_W-1:0]   tk_q;
	logic [SL_W-1:0]   sl_q;
	logic [5:0]        idx_q;
	logic [ADDR_W-1:0] scan_addr;
	logic              snap_begin;

	// Table memory.
	entry_t            rd_entry;
	entry_t            wr_entry;
	logic [ENTRY_W-1:0] rd_raw;
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;

	// Update check.
	logic [1:0] err;
	logic       gap;
	logic       table_op;

	// Output register.
	logic out_valid_q;
	rec_t out_rec_q;
	rec_t rec_d;

	// Slot address of the incoming item; out-of-range addresses fall back to zero.
	always_comb begin
		in_range = (32'(in_item.ticker) < 32'(TICKERS))
			&& (32'(in_item.order_slot) < 32'(ORDER_SLOTS));
		if (in_range) begin
			in_addr = ADDR_W'(32'(in_item.ticker) * ORDER_SLOTS + 32'(in_item.order_slot));
		end else begin
			in_addr = '0;
		end
	end

	assign scan_addr = ADDR_W'(32'(tk_q) * ORDER_SLOTS + 32'(sl_q));

	// Saturating tick count and snapshot trigger.
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
	assign snap_begin  = cmd.accept && (in_item.func == FUNC_TICK) && (elapsed_inc > period_q);

	// Slot and sequence checks for the registered update.
	always_comb begin
		table_op = (item_q.update_type == UPD_ADD) || (item_q.update_type == UPD_MODIFY)
			|| (item_q.update_type == UPD_CANCEL);
		err = ERR_NONE;
		if (table_op) begin
			if (!in_range_q) begin
				err = ERR_EMPTY;
			end else if (item_q.update_type == UPD_ADD) begin
				err = valid_q[addr_q] ? ERR_OCCUPIED : ERR_NONE;
			end else if (!valid_q[addr_q]) begin
				err = ERR_EMPTY;
			end else if (rd_entry.side != item_q.side) begin
				err = ERR_SIDE;
			end
		end
		gap = (item_q.seq_num != last_seq_q + 32'd1);
	end

	// Memory ports: reads on accept and during the walk, writes on commit of an add or modify.
	assign rd_entry  = entry_t'(rd_raw);
	assign ram_re    = cmd.accept || cmd.scan_read;
	assign ram_raddr = cmd.accept ? in_addr : scan_addr;
	assign ram_we    = cmd.commit && ((item_q.update_type == UPD_ADD)
		|| (item_q.update_type == UPD_MODIFY));

	always_comb begin
		wr_entry.price    = item_q.price;
		wr_entry.quantity = item_q.quantity;
		if (item_q.update_type == UPD_ADD) begin
			wr_entry.side         = item_q.side;
			wr_entry.priority_val = item_q.priority_req;
		end else begin
			wr_entry.side         = rd_entry.side;
			wr_entry.priority_val = rd_entry.priority_val;
		end
	end

	obst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TOTAL_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_raw)
	);

	// Status to the controller.
	always_comb begin
		stat.in_tick     = (in_item.func == FUNC_TICK);
		stat.snap_due    = (elapsed_inc > period_q);
		stat.broken      = (err != ERR_NONE) || gap;
		stat.out_free    = !out_valid_q || out_ready;
		stat.scan_valid  = valid_q[scan_addr];
		stat.slot_last   = (sl_q == SL_W'(ORDER_SLOTS - 1));
		stat.ticker_last = (tk_q == TK_W'(TICKERS - 1));
	end

	// Record assembly for the kind the controller asks for.
	always_comb begin
		rec_d          = '0;
		rec_d.msg_kind = cmd.emit_kind;
		case (cmd.emit_kind)
			KIND_ERROR: begin
				rec_d.error_code = err;
				rec_d.seq_gap    = gap;
				rec_d.last       = 1'b1;
			end
			KIND_START: begin
				rec_d.msg_index = idx_q;
				rec_d.out_seq   = last_seq_q;
			end
			KIND_CLEAR: begin
				rec_d.msg_index  = idx_q;
				rec_d.out_ticker = 2'(tk_q);
			end
			KIND_ORDER: begin
				rec_d.msg_index    = idx_q;
				rec_d.out_ticker   = 2'(tk_q);
				rec_d.out_slot     = 3'(sl_q);
				rec_d.out_side     = rd_entry.side;
				rec_d.out_price    = rd_entry.price;
				rec_d.out_quantity = rd_entry.quantity;
				rec_d.out_priority = rd_entry.priority_val;
			end
			KIND_END: begin
				rec_d.msg_index = idx_q;
				rec_d.out_seq   = last_seq_q;
				rec_d.last      = 1'b1;
			end
			default: begin
				rec_d.msg_kind = cmd.emit_kind;
			end
		endcase
	end

	// Control registers: period, counters, live flags, walk position, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			elapsed_q   <= '0;
			last_seq_q  <= '0;
			valid_q     <= '0;
			tk_q        <= '0;
			sl_q        <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_data;
			end
			if (cmd.accept && (in_item.func == FUNC_TICK)) begin
				elapsed_q <= snap_begin ? 32'd0 : elapsed_inc;
			end
			if (cmd.commit) begin
				last_seq_q <= item_q.seq_num;
				if (item_q.update_type == UPD_ADD) begin
					valid_q[addr_q] <= 1'b1;
				end else if (item_q.update_type == UPD_CANCEL) begin
					valid_q[addr_q] <= 1'b0;
				end
			end
			if (snap_begin) begin
				tk_q  <= '0;
				sl_q  <= '0;
				idx_q <= '0;
			end else begin
				if (cmd.walk_next) begin
					if (stat.slot_last) begin
						sl_q <= '0;
						tk_q <= tk_q + TK_W'(1);
					end else begin
						sl_q <= sl_q + SL_W'(1);
					end
				end
				if (cmd.emit && (cmd.emit_kind != KIND_ERROR)) begin
					idx_q <= idx_q + 6'd1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q     <= in_item;
			addr_q     <= in_addr;
			in_range_q <= in_range;
		end
		if (cmd.emit) begin
			out_rec_q <= rec_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;

endmodule

/* hw/rtl/order_book_snapshot_table.sv */
// Channel   | Direction | Handshake                      | Content
// ----------+-----------+--------------------------------+------------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | market updates and time ticks
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | error and snapshot records
// cfg       | in        | cfg_valid / cfg_ready          | snapshot_period register
//
// An update is accepted in IDLE, where its slot is read from the table memory, then
// checked and written back in CHECK; an error goes on to ERROR to load its record.
// A tick is taken in IDLE. A snapshot walks every slot once in SCAN, with an ORDER record
// per live order, a CLEAR per ticker, and START and END, paced by the single read port.
// Reset clears the live-order flags and counters at once; there is no clearing pass.
// A stalled m_axis holds the walk and the input; once END or ERROR is loaded, input resumes.
module order_book_snapshot_table import obst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,

	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [1:0] ticker, [4:2] order_slot, [6:5] side, [38:7] price, [70:39] quantity,
	// [102:71] priority_req, [134:103] seq_num, [135] zero
	input  logic [135:0] s_axis_tdata,
	// [0] func, [3:1] update_type
	input  logic [3:0]   s_axis_tuser,

	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [5:0] msg_index, [7:6] out_ticker, [10:8] out_slot, [12:11] out_side,
	// [44:13] out_price, [76:45] out_quantity, [108:77] out_priority,
	// [140:109] out_seq, [142:141] error_code, [143] seq_gap
	output logic [143:0] m_axis_tdata,
	// [2:0] msg_kind
	output logic [2:0]   m_axis_tuser,
	output logic         m_axis_tlast,

	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);

	item_t in_item;
	rec_t  out_rec;
	cmd_t  cmd;
	stat_t stat;

	// Unpack the input transaction.
	always_comb begin
		in_item.func         = s_axis_tuser[0];
		in_item.update_type  = s_axis_tuser[3:1];
		in_item.ticker       = s_axis_tdata[1:0];
		in_item.order_slot   = s_axis_tdata[4:2];
		in_item.side         = s_axis_tdata[6:5];
		in_item.price        = s_axis_tdata[38:7];
		in_item.quantity     = s_axis_tdata[70:39];
		in_item.priority_req = s_axis_tdata[102:71];
		in_item.seq_num      = s_axis_tdata[134:103];
	end

	// Pack the output transaction.
	assign m_axis_tdata = {out_rec.seq_gap, out_rec.error_code, out_rec.out_seq,
		out_rec.out_priority, out_rec.out_quantity, out_rec.out_price,
		out_rec.out_side, out_rec.out_slot, out_rec.out_ticker, out_rec.msg_index};
	assign m_axis_tuser = out_rec.msg_kind;
	assign m_axis_tlast = out_rec.last;

	// The register accepts a write in any cycle.
	assign cfg_ready = 1'b1;

	obst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	obst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_rec   (out_rec)
	);

endmodule

/* tb/tb_order_book_snapshot_table.sv */
`timescale 1ns / 1ps

module tb_order_book_snapshot_table;
	import obst_pkg::*;

	// Update types and sides that the package does not name.
	localparam logic [2:0] UPD_TRADE      = 3'd3;
	localparam logic [2:0] UPD_CLEAR      = 3'd4;
	localparam logic [2:0] UPD_SNAP_START = 3'd5;
	localparam logic [2:0] UPD_SNAP_END   = 3'd6;
	localparam logic [2:0] UPD_INVALID    = 3'd7;
	localparam logic [1:0] SIDE_NONE      = 2'd0;
	localparam logic [1:0] SIDE_BUY       = 2'd1;
	localparam logic [1:0] SIDE_SELL      = 2'd2;

	// Quiet cycles allowed before the run is declared hung, and settling time.
	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_PRINTS    = 30;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic [3:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [31:0]  cfg_data;

	// Shadow copy of the order table and its counters.
	bit          book_live  [TOTAL_SLOTS];
	logic [1:0]  book_side  [TOTAL_SLOTS];
	logic [31:0] book_price [TOTAL_SLOTS];
	logic [31:0] book_qty   [TOTAL_SLOTS];
	logic [31:0] book_prio  [TOTAL_SLOTS];
	logic [31:0] book_seq;
	logic [31:0] book_elapsed;
	logic [31:0] book_period;

	// Records the block still owes, oldest first.
	rec_t due_records[$];

	int mismatches;
	int rec_seen;
	int rx_hold_cycles;
	bit tx_idle;
	bit rx_idle;

	order_book_snapshot_table u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic void book_reset();
		for (int a = 0; a < TOTAL_SLOTS; a++) begin
			book_live[a]  = 1'b0;
			book_side[a]  = '0;
			book_price[a] = '0;
			book_qty[a]   = '0;
			book_prio[a]  = '0;
		end
		book_seq     = '0;
		book_elapsed = '0;
		book_period  = PERIOD_RESET;
	endfunction

	// A snapshot: start, then per ticker a clear and its live orders, then end.
	function automatic void publish_snapshot();
		rec_t r;
		int   idx;
		idx = 0;
		r = '0;
		r.msg_index = idx[5:0];
		r.msg_kind  = KIND_START;
		r.out_seq   = book_seq;
		due_records.push_back(r);
		idx++;
		for (int t = 0; t < TICKERS; t++) begin
			r = '0;
			r.msg_index  = idx[5:0];
			r.msg_kind   = KIND_CLEAR;
			r.out_ticker = t[1:0];
			due_records.push_back(r);
			idx++;
			for (int s = 0; s < ORDER_SLOTS; s++) begin
				if (book_live[t * ORDER_SLOTS + s]) begin
					r = '0;
					r.msg_index    = idx[5:0];
					r.msg_kind     = KIND_ORDER;
					r.out_ticker   = t[1:0];
					r.out_slot     = s[2:0];
					r.out_side     = book_side[t * ORDER_SLOTS + s];
					r.out_price    = book_price[t * ORDER_SLOTS + s];
					r.out_quantity = book_qty[t * ORDER_SLOTS + s];
					r.out_priority = book_prio[t * ORDER_SLOTS + s];
					due_records.push_back(r);
					idx++;
				end
			end
		end
		r = '0;
		r.msg_index = idx[5:0];
		r.msg_kind  = KIND_END;
		r.out_seq   = book_seq;
		r.last      = 1'b1;
		due_records.push_back(r);
	endfunction

	// Applies one accepted item to the shadow table and queues what it causes.
	function automatic void book_apply(item_t it);
		int         a;
		bit         in_range;
		logic [1:0] err;
		logic       gap;
		rec_t       r;
		if (it.func == FUNC_TICK) begin
			if (book_elapsed != '1)
				book_elapsed = book_elapsed + 32'd1;
			if (book_elapsed > book_period) begin
				book_elapsed = '0;
				publish_snapshot();
			end
			return;
		end
		in_range = (int'(it.ticker) < TICKERS) && (int'(it.order_slot) < ORDER_SLOTS);
		a = in_range ? int'(it.ticker) * ORDER_SLOTS + int'(it.order_slot) : 0;
		err = ERR_NONE;
		if (it.update_type <= UPD_CANCEL) begin
			if (!in_range)
				err = ERR_EMPTY;
			else if (it.update_type == UPD_ADD)
				err = book_live[a] ? ERR_OCCUPIED : ERR_NONE;
			else if (!book_live[a])
				err = ERR_EMPTY;
			else if (book_side[a] != it.side)
				err = ERR_SIDE;
		end
		gap = (it.seq_num != book_seq + 32'd1);
		// A broken update leaves everything untouched and yields one error record.
		if (err != ERR_NONE || gap) begin
			r = '0;
			r.msg_kind   = KIND_ERROR;
			r.error_code = err;
			r.seq_gap    = gap;
			r.last       = 1'b1;
			due_records.push_back(r);
			return;
		end
		case (it.update_type)
			UPD_ADD: begin
				book_live[a]  = 1'b1;
				book_side[a]  = it.side;
				book_price[a] = it.price;
				book_qty[a]   = it.quantity;
				book_prio[a]  = it.priority_req;
			end
			UPD_MODIFY: begin
				book_price[a] = it.price;
				book_qty[a]   = it.quantity;
			end
			UPD_CANCEL: begin
				book_live[a] = 1'b0;
			end
			default: ;
		endcase
		book_seq = it.seq_num;
	endfunction

	function automatic logic [31:0] next_seq();
		return book_seq + 32'd1;
	endfunction

	function automatic item_t random_fields();
		item_t it;
		it.func         = FUNC_UPDATE;
		it.update_type  = 3'($urandom_range(0, 7));
		it.ticker       = 2'($urandom_range(0, TICKERS - 1));
		it.order_slot   = 3'($urandom_range(0, ORDER_SLOTS - 1));
		it.side         = 2'($urandom_range(0, 2));
		it.price        = $urandom;
		it.quantity     = $urandom;
		it.priority_req = $urandom;
		it.seq_num      = $urandom;
		return it;
	endfunction

	// Ticks carry random junk in every other field.
	function automatic item_t tick_item();
		item_t it;
		it = random_fields();
		it.func = FUNC_TICK;
		return it;
	endfunction

	function automatic item_t order_item(logic [2:0] kind, int tk, int sl, logic [1:0] sd,
			logic [31:0] px, logic [31:0] qty, logic [31:0] prio, logic [31:0] seq);
		item_t it;
		it.func         = FUNC_UPDATE;
		it.update_type  = kind;
		it.ticker       = tk[1:0];
		it.order_slot   = sl[2:0];
		it.side         = sd;
		it.price        = px;
		it.quantity     = qty;
		it.priority_req = prio;
		it.seq_num      = seq;
		return it;
	endfunction

	// Mostly well-formed updates against the current table, with some broken ones.
	function automatic item_t random_update();
		item_t it;
		int    pick;
		int    start;
		int    found;
		int    a;
		it = random_fields();
		it.seq_num = next_seq();
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			it.update_type = UPD_ADD;
			for (int tries = 0; tries < 4; tries++) begin
				if (book_live[int'(it.ticker) * ORDER_SLOTS + int'(it.order_slot)]) begin
					it.ticker     = 2'($urandom_range(0, TICKERS - 1));
					it.order_slot = 3'($urandom_range(0, ORDER_SLOTS - 1));
				end
			end
			it.side = ($urandom_range(0, 19) == 0) ? SIDE_NONE : 2'($urandom_range(1, 2));
		end else if (pick < 80) begin
			it.update_type = (pick < 60) ? UPD_MODIFY : UPD_CANCEL;
			start = $urandom_range(0, TOTAL_SLOTS - 1);
			found = -1;
			for (int i = 0; i < TOTAL_SLOTS; i++) begin
				a = (start + i) % TOTAL_SLOTS;
				if (book_live[a] && found < 0)
					found = a;
			end
			if (found >= 0) begin
				it.ticker     = 2'(found / ORDER_SLOTS);
				it.order_slot = 3'(found % ORDER_SLOTS);
				it.side       = book_side[found];
				if ($urandom_range(0, 9) == 0)
					it.side = 2'($urandom_range(0, 2));
			end
		end else begin
			it.update_type = 3'($urandom_range(UPD_TRADE, UPD_INVALID));
		end
		if ($urandom_range(0, 99) < 8)
			it.seq_num = ($urandom_range(0, 1) == 0) ? book_seq : 32'($urandom);
		return it;
	endfunction

	// Offers one item and waits for its transaction, then predicts its results.
	task automatic send_item(item_t it);
		int gap;
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			gap = gap_len();
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, it.seq_num, it.priority_req, it.quantity, it.price,
				it.side, it.order_slot, it.ticker};
		s_axis_tuser  <= {it.update_type, it.func};
		do @(posedge clk); while (!s_axis_tready);
		book_apply(it);
	endtask

	// Stops offering and waits until every owed record has come out.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (due_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_snapshot_period(logic [31:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		book_period = value;
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("record %0d %s: got 0x%0h expected 0x%0h", rec_seen, what, got, want);
	endtask

	// Compares one output transaction with the oldest owed record.
	task automatic check_record();
		rec_t got;
		rec_t want;
		got.msg_index    = m_axis_tdata[5:0];
		got.msg_kind     = m_axis_tuser;
		got.out_ticker   = m_axis_tdata[7:6];
		got.out_slot     = m_axis_tdata[10:8];
		got.out_side     = m_axis_tdata[12:11];
		got.out_price    = m_axis_tdata[44:13];
		got.out_quantity = m_axis_tdata[76:45];
		got.out_priority = m_axis_tdata[108:77];
		got.out_seq      = m_axis_tdata[140:109];
		got.error_code   = m_axis_tdata[142:141];
		got.seq_gap      = m_axis_tdata[143];
		got.last         = m_axis_tlast;
		rec_seen++;
		if (due_records.size() == 0) begin
			report_mismatch("unexpected record, kind", 32'(got.msg_kind), '0);
			return;
		end
		want = due_records.pop_front();
		if (got.msg_index != want.msg_index)
			report_mismatch("msg_index", 32'(got.msg_index), 32'(want.msg_index));
		if (got.msg_kind != want.msg_kind)
			report_mismatch("msg_kind", 32'(got.msg_kind), 32'(want.msg_kind));
		if (got.out_ticker != want.out_ticker)
			report_mismatch("out_ticker", 32'(got.out_ticker), 32'(want.out_ticker));
		if (got.out_slot != want.out_slot)
			report_mismatch("out_slot", 32'(got.out_slot), 32'(want.out_slot));
		if (got.out_side != want.out_side)
			report_mismatch("out_side", 32'(got.out_side), 32'(want.out_side));
		if (got.out_price != want.out_price)
			report_mismatch("out_price", got.out_price, want.out_price);
		if (got.out_quantity != want.out_quantity)
			report_mismatch("out_quantity", got.out_quantity, want.out_quantity);
		if (got.out_priority != want.out_priority)
			report_mismatch("out_priority", got.out_priority, want.out_priority);
		if (got.out_seq != want.out_seq)
			report_mismatch("out_seq", got.out_seq, want.out_seq);
		if (got.error_code != want.error_code)
			report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
		if (got.seq_gap != want.seq_gap)
			report_mismatch("seq_gap", 32'(got.seq_gap), 32'(want.seq_gap));
		if (got.last != want.last)
			report_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	// Output checker.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				check_record();
		end
	end

	// Receiver pacing: random stalls, plus a long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				stall_left = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (rx_idle && $urandom_range(0, 4) == 0)
					stall_left = gap_len();
			end
		end
	end

	// Watchdog on cycles without any transaction.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("order_book_snapshot_table regression: fail");
				$finish;
			end
		end
	end

	// Extremes of the fields, every update type and every error case.
	task automatic test_directed_updates();
		logic [2:0] seq_only_types [5] = '{UPD_TRADE, UPD_CLEAR, UPD_SNAP_START,
				UPD_SNAP_END, UPD_INVALID};
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_item(order_item(UPD_ADD, 0, 0, SIDE_BUY, 32'h8000_0000, '0, '0, next_seq()));
		send_item(order_item(UPD_ADD, TICKERS - 1, ORDER_SLOTS - 1, SIDE_SELL,
				32'h7fff_ffff, '1, '1, next_seq()));
		// Add on an occupied slot.
		send_item(order_item(UPD_ADD, TICKERS - 1, ORDER_SLOTS - 1, SIDE_SELL, 1, 1, 1,
				next_seq()));
		send_item(order_item(UPD_MODIFY, 0, 0, SIDE_BUY, 5, 7, 9, next_seq()));
		// Modify of an empty slot, then side mismatches on modify and cancel.
		send_item(order_item(UPD_MODIFY, 1, 2, SIDE_BUY, 5, 7, 9, next_seq()));
		send_item(order_item(UPD_MODIFY, TICKERS - 1, ORDER_SLOTS - 1, SIDE_BUY, 3, 3, 3,
				next_seq()));
		send_item(order_item(UPD_CANCEL, TICKERS - 1, ORDER_SLOTS - 1, SIDE_NONE, 0, 0, 0,
				next_seq()));
		send_item(order_item(UPD_CANCEL, TICKERS - 1, ORDER_SLOTS - 1, SIDE_SELL, 0, 0, 0,
				next_seq()));
		// Cancel of a slot that is now empty.
		send_item(order_item(UPD_CANCEL, TICKERS - 1, ORDER_SLOTS - 1, SIDE_SELL, 0, 0, 0,
				next_seq()));
		// Types that only advance the sequence number.
		foreach (seq_only_types[k])
			send_item(order_item(seq_only_types[k], $urandom_range(0, 3),
					$urandom_range(0, 7), 2'($urandom_range(0, 2)), $urandom, $urandom,
					$urandom, next_seq()));
		// Sequence gap alone, a repeated number with a slot error, and an all-ones number.
		send_item(order_item(UPD_ADD, 1, 1, SIDE_BUY, 1, 1, 1, next_seq() + 32'd5));
		send_item(order_item(UPD_MODIFY, 1, 4, SIDE_BUY, 1, 1, 1, book_seq));
		send_item(order_item(UPD_TRADE, 0, 0, SIDE_NONE, 0, 0, 0, '1));
		// Add with no side, and the far slot again with extreme contents.
		send_item(order_item(UPD_ADD, 2, 3, SIDE_NONE, 32'hffff_ffff, '1, 32'h8000_0001,
				next_seq()));
		send_item(order_item(UPD_ADD, TICKERS - 1, ORDER_SLOTS - 1, SIDE_SELL,
				32'h8000_0000, 32'h0000_0001, '0, next_seq()));
		send_item(tick_item());
		send_item(tick_item());
		drain_results();
	endtask

	// Under the reset period a short run of back-to-back ticks gives no snapshot.
	task automatic test_reset_period();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (20) send_item(tick_item());
		drain_results();
	endtask

	// Long receiver hold-off during snapshots, which holds the input stream behind it.
	task automatic test_output_backpressure();
		set_snapshot_period(32'd1);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		for (int a = 0; a < TOTAL_SLOTS; a++)
			if (!book_live[a] && $urandom_range(0, 3) != 0)
				send_item(order_item(UPD_ADD, a / ORDER_SLOTS, a % ORDER_SLOTS,
						2'($urandom_range(1, 2)), $urandom, $urandom, $urandom,
						next_seq()));
		rx_hold_cycles = 400;
		repeat (12) send_item(tick_item());
		drain_results();
	endtask

	// Random streams over several small periods, with and without idling.
	task automatic test_random_stream();
		for (int phase = 0; phase < 4; phase++) begin
			set_snapshot_period($urandom_range(1, 12));
			tx_idle = phase[0];
			rx_idle = phase[0];
			repeat (45)
				send_item(($urandom_range(0, 99) < 15) ? tick_item() : random_update());
		end
	endtask

	// Period of all ones never snapshots; period one snapshots every other tick.
	task automatic test_period_extremes();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		set_snapshot_period('1);
		repeat (30)
			send_item(($urandom_range(0, 99) < 30) ? tick_item() : random_update());
		set_snapshot_period(32'd1);
		repeat (30)
			send_item(($urandom_range(0, 99) < 30) ? tick_item() : random_update());
	endtask

	initial begin
		mismatches     = 0;
		rec_seen       = 0;
		rx_hold_cycles = 0;
		tx_idle        = 1'b0;
		rx_idle        = 1'b0;
		book_reset();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_updates();
		test_reset_period();
		test_output_backpressure();
		test_random_stream();
		test_period_extremes();
		drain_results();
		if (mismatches == 0)
			$display("order_book_snapshot_table regression: pass");
		else
			$display("order_book_snapshot_table regression: fail");
		$finish;
	end

endmodule

/* order_book_snapshot_table.f */
hw/rtl/obst_pkg.sv
hw/rtl/obst_ram.sv
hw/rtl/obst_ctrl.sv
hw/rtl/obst_dp.sv
hw/rtl/order_book_snapshot_table.sv
tb/tb_order_book_snapshot_table.sv
